/* src/deq_pkg.sv */
`timescale 1ns / 1ps

package deq_pkg;

  localparam int ACTION_W = 2;
  localparam int CAP_W    = 8;
  localparam int COUNT_W  = 8;
  localparam logic [CAP_W-1:0] CAP_RESET = 8'd255;

  // Cells ORed together in the first, registered level of the tail tree.
  localparam int GROUP = 16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_REAR  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_REAR   = 2'd3
  } deq_action_e;

  // Command broadcast to every cell of the row; at most one bit is set.
  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
    logic flush;
  } deq_cell_cmd_t;

endpackage

/* src/deq_if.sv */
`timescale 1ns / 1ps

interface deq_in_if #(
  parameter int W = 32
) ();
  logic                          valid;
  logic                          ready;
  logic [deq_pkg::ACTION_W-1:0]  action;
  logic [W-1:0]                  value_in;

  modport source (output valid, action, value_in, input ready);
  modport sink   (input valid, action, value_in, output ready);
endinterface

interface deq_out_if #(
  parameter int W = 32
) ();
  logic                          valid;
  logic                          ready;
  logic [W-1:0]                  value_out;
  logic                          empty_error;
  logic                          full_error;
  logic [deq_pkg::COUNT_W-1:0]   count_after;

  modport source (output valid, value_out, empty_error, full_error, count_after,
                  input ready);
  modport sink   (input valid, value_out, empty_error, full_error, count_after,
                  output ready);
endinterface

interface deq_cfg_if ();
  logic                          valid;
  logic                          ready;
  logic [deq_pkg::CAP_W-1:0]     capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

/* src/deq_cell.sv */
`timescale 1ns / 1ps

module deq_cell #(
  parameter int W = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  deq_pkg::deq_cell_cmd_t cmd_i,
  input  logic [W-1:0]           push_value_i,
  input  logic [W-1:0]           left_data_i,
  input  logic                   left_valid_i,
  input  logic [W-1:0]           right_data_i,
  input  logic                   right_valid_i,
  output logic [W-1:0]           data_o,
  output logic                   valid_o,
  output logic [W-1:0]           tap_o
);

  logic [W-1:0] data_q, data_d;
  logic         valid_q, valid_d;
  logic         is_tail;

  assign is_tail = valid_q & ~right_valid_i;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    priority if (cmd_i.flush) begin
      valid_d = 1'b0;
    end else if (cmd_i.push_front) begin
      // shift toward the rear, take the neighbor on the front side
      data_d  = left_data_i;
      valid_d = left_valid_i;
    end else if (cmd_i.pop_front) begin
      data_d  = right_data_i;
      valid_d = right_valid_i;
    end else if (cmd_i.push_rear) begin
      if (!valid_q && left_valid_i) begin
        data_d  = push_value_i;
        valid_d = 1'b1;
      end
    end else if (cmd_i.pop_rear) begin
      if (is_tail) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;
  assign tap_o   = is_tail ? data_q : '0;

endmodule

/* src/deq_tail_tree.sv */
`timescale 1ns / 1ps

module deq_tail_tree #(
  parameter int W      = 32,
  parameter int NCELLS = 255
) (
  input  logic         clk_i,
  input  logic [W-1:0] taps_i [NCELLS],
  output logic [W-1:0] rear_value_o
);

  localparam int NGROUPS = (NCELLS + deq_pkg::GROUP - 1) / deq_pkg::GROUP;
  localparam int PADDED  = NGROUPS * deq_pkg::GROUP;

  logic [W-1:0] padded [PADDED];
  logic [W-1:0] group_d [NGROUPS];
  logic [W-1:0] group_q [NGROUPS];

  for (genvar j = 0; j < PADDED; j++) begin : g_pad
    if (j < NCELLS) begin : g_tap
      assign padded[j] = taps_i[j];
    end else begin : g_zero
      assign padded[j] = '0;
    end
  end

  always_comb begin
    for (int g = 0; g < NGROUPS; g++) begin
      group_d[g] = '0;
      for (int k = 0; k < deq_pkg::GROUP; k++) begin
        group_d[g] = group_d[g] | padded[g * deq_pkg::GROUP + k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    group_q <= group_d;
  end

  // At most one tap is nonzero, so the OR of the groups is the tail value.
  always_comb begin
    rear_value_o = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      rear_value_o = rear_value_o | group_q[g];
    end
  end

endmodule

/* src/double_ended_queue_core.sv */
`timescale 1ns / 1ps
// Double-ended queue built as a row of storage cells, front element in cell 0.
// Channels (valid/ready, a transfer happens when both are high):
//   in_ch  : one operation per transfer: action (push front, push rear,
//            pop front, pop rear) and value_in for pushes.
//   out_ch : exactly one result per operation: popped value (zero for pushes
//            and empty pops), empty_error, full_error, count_after.
//   cfg_ch : capacity write; clamps to 1..NCELLS and empties the queue.
// The result is registered. Pushes, pop front and pops on an empty queue show
// on out_ch the cycle after the input transfer, so one such operation per cycle
// is sustained while out_ch takes each result. A pop rear on a non-empty queue
// passes through ST_TREE and ST_FINISH and takes no new operation meanwhile;
// the row's tail value comes from a two-level OR tree, first level registered.
// A push on a full queue is refused (full_error, contents kept).
// Reset empties the queue and sets capacity to 255; stored values are not
// cleared, only the per-cell occupancy bits. When out_ch stalls, the result
// holds in the output register and in_ch drops ready until it is taken.

module double_ended_queue_core #(
  parameter int SLOTS      = 256,
  parameter int ELEM_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  deq_in_if.sink   in_ch,
  deq_out_if.source out_ch,
  deq_cfg_if.sink  cfg_ch
);

  // Capacity never exceeds 255 (8-bit register), so extra slots stay unused.
  localparam int NCELLS = (SLOTS - 1 < 255) ? (SLOTS - 1) : 255;
  localparam logic [deq_pkg::CAP_W-1:0] MAX_CAP = deq_pkg::CAP_W'(NCELLS);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_TREE,
    ST_FINISH
  } state_e;

  state_e                        state_q;
  logic [deq_pkg::CAP_W-1:0]     cap_q;
  logic [deq_pkg::COUNT_W-1:0]   count_q;
  logic                          out_valid_q;
  logic [ELEM_WIDTH-1:0]         out_value_q;
  logic                          out_empty_q;
  logic                          out_full_q;
  logic [deq_pkg::COUNT_W-1:0]   out_count_q;

  logic [deq_pkg::CAP_W-1:0]     last_cap;
  logic                          is_full;
  logic                          is_empty;
  logic                          out_free;
  logic                          in_fire;
  logic                          cfg_fire;
  deq_pkg::deq_action_e          act;
  deq_pkg::deq_cell_cmd_t        cmd;

  logic [ELEM_WIDTH-1:0]         cell_data [NCELLS];
  logic [ELEM_WIDTH-1:0]         cell_tap  [NCELLS];
  logic [NCELLS-1:0]             cell_vld;
  logic [ELEM_WIDTH-1:0]         rear_value;

  // Effective capacity: zero counts as one, anything above the row is clipped.
  always_comb begin
    if (cap_q == '0) begin
      last_cap = deq_pkg::CAP_W'(1);
    end else if (cap_q > MAX_CAP) begin
      last_cap = MAX_CAP;
    end else begin
      last_cap = cap_q;
    end
  end

  assign is_full  = (count_q >= last_cap);
  assign is_empty = (count_q == '0);
  assign out_free = ~out_valid_q | out_ch.ready;
  assign act      = deq_pkg::deq_action_e'(in_ch.action);

  // A pending capacity write holds off operations so both never land together.
  assign in_ch.ready  = (state_q == ST_RUN) & out_free & ~cfg_ch.valid;
  assign cfg_ch.ready = (state_q == ST_RUN);
  assign in_fire      = in_ch.valid & in_ch.ready;
  assign cfg_fire     = cfg_ch.valid & cfg_ch.ready;

  // Broadcast one command to the whole row.
  always_comb begin
    cmd = '0;
    if (cfg_fire) begin
      cmd.flush = 1'b1;
    end else if (in_fire) begin
      unique case (act)
        deq_pkg::ACT_PUSH_FRONT: cmd.push_front = ~is_full;
        deq_pkg::ACT_PUSH_REAR:  cmd.push_rear  = ~is_full;
        deq_pkg::ACT_POP_FRONT:  cmd.pop_front  = ~is_empty;
        deq_pkg::ACT_POP_REAR:   cmd.pop_rear   = 1'b0;  // handled by the tree
        default:                 cmd            = '0;
      endcase
    end else if (state_q == ST_FINISH && out_free) begin
      cmd.pop_rear = 1'b1;
    end
  end

  // Row of cells: cell 0 sees the incoming value as its front-side neighbor,
  // the last cell sees an empty neighbor on its rear side.
  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    logic [ELEM_WIDTH-1:0] left_data;
    logic                  left_valid;
    logic [ELEM_WIDTH-1:0] right_data;
    logic                  right_valid;

    if (i == 0) begin : g_head
      assign left_data  = in_ch.value_in;
      assign left_valid = 1'b1;
    end else begin : g_body
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_vld[i-1];
    end

    if (i == NCELLS - 1) begin : g_end
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid
      assign right_data  = cell_data[i+1];
      assign right_valid = cell_vld[i+1];
    end

    deq_cell #(
      .W (ELEM_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .push_value_i  (in_ch.value_in),
      .left_data_i   (left_data),
      .left_valid_i  (left_valid),
      .right_data_i  (right_data),
      .right_valid_i (right_valid),
      .data_o        (cell_data[i]),
      .valid_o       (cell_vld[i]),
      .tap_o         (cell_tap[i])
    );
  end

  deq_tail_tree #(
    .W      (ELEM_WIDTH),
    .NCELLS (NCELLS)
  ) u_tail_tree (
    .clk_i        (clk_i),
    .taps_i       (cell_tap),
    .rear_value_o (rear_value)
  );

  // Sequencer, counters and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      cap_q       <= deq_pkg::CAP_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_empty_q <= 1'b0;
      out_full_q  <= 1'b0;
      out_count_q <= '0;
    end else begin
      // drop the result once it has been transferred
      if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_fire) begin
        cap_q   <= cfg_ch.capacity;
        count_q <= '0;
      end

      unique case (state_q)
        ST_RUN: begin
          if (in_fire) begin
            out_value_q <= '0;
            out_empty_q <= 1'b0;
            out_full_q  <= 1'b0;
            out_count_q <= count_q;
            out_valid_q <= 1'b1;
            unique case (act)
              deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_REAR: begin
                if (is_full) begin
                  out_full_q <= 1'b1;
                end else begin
                  count_q     <= count_q + 1'b1;
                  out_count_q <= count_q + 1'b1;
                end
              end
              deq_pkg::ACT_POP_FRONT: begin
                if (is_empty) begin
                  out_empty_q <= 1'b1;
                end else begin
                  out_value_q <= cell_data[0];
                  count_q     <= count_q - 1'b1;
                  out_count_q <= count_q - 1'b1;
                end
              end
              deq_pkg::ACT_POP_REAR: begin
                if (is_empty) begin
                  out_empty_q <= 1'b1;
                end else begin
                  // hold the result until the tree has gathered the tail
                  out_valid_q <= 1'b0;
                  state_q     <= ST_TREE;
                end
              end
              default: begin
                out_valid_q <= 1'b0;
              end
            endcase
          end
        end
        ST_TREE: begin
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_value_q <= rear_value;
            out_empty_q <= 1'b0;
            out_full_q  <= 1'b0;
            out_count_q <= count_q - 1'b1;
            count_q     <= count_q - 1'b1;
            state_q     <= ST_RUN;
          end
        end
        default: begin
          state_q <= ST_RUN;
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.value_out   = out_value_q;
  assign out_ch.empty_error = out_empty_q;
  assign out_ch.full_error  = out_full_q;
  assign out_ch.count_after = out_count_q;

  // The occupancy bits of the row and the element count must agree.
  a_count_matches_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_vld) == int'(count_q))
    else $error("element count differs from occupied cells");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= last_cap)
    else $error("element count above capacity");

  a_errors_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_empty_q && out_full_q))
    else $error("empty and full error raised together");

  a_row_packed_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> cell_vld[0])
    else $error("non-empty queue with a hole at the front");

  a_tree_then_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TREE) |=> (state_q == ST_FINISH))
    else $error("tail gather did not advance");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int ELEM_W  = 32;
  localparam int SLOT_N  = 256;
  localparam int CAP_W   = deq_pkg::CAP_W;
  localparam int COUNT_W = deq_pkg::COUNT_W;
  // Generous bound: every item waiting out the longest sender gap, the longest
  // receiver stall and the slow pop rear still finishes far inside this.
  localparam int unsigned RUN_LIMIT_NS = 2_000_000;

  typedef struct packed {
    deq_pkg::deq_action_e action;
    logic [ELEM_W-1:0]    value;
  } deq_op_t;

  typedef struct packed {
    logic [ELEM_W-1:0]  value_out;
    logic               empty_error;
    logic               full_error;
    logic [COUNT_W-1:0] count_after;
  } deq_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  deq_in_if  #(.W(ELEM_W)) in_ch ();
  deq_out_if #(.W(ELEM_W)) out_ch ();
  deq_cfg_if               cfg_ch ();

  double_ended_queue_core #(
    .SLOTS     (SLOT_N),
    .ELEM_WIDTH(ELEM_W)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #5 clk_i = ~clk_i;

  // Operations still to be offered, and the replies the shadow deque predicts
  // for operations already transferred, oldest first.
  deq_op_t    pending_ops[$];
  deq_reply_t expected_replies[$];
  int unsigned mismatch_count = 0;

  // Shadow copy of the deque: ring storage, both free-slot pointers, the
  // element count and the capacity register.
  logic [ELEM_W-1:0]  slot_mem [SLOT_N];
  logic [CAP_W-1:0]   shadow_cap;
  logic [CAP_W-1:0]   shadow_front;
  logic [CAP_W-1:0]   shadow_rear;
  logic [COUNT_W-1:0] shadow_count;

  // Apply one operation to the shadow deque and return the reply it implies.
  function automatic deq_reply_t shadow_deque_apply(deq_op_t op);
    deq_reply_t       r;
    logic [CAP_W-1:0] last;
    r = '0;
    // Capacity zero behaves as capacity one; the ring spans slots 0..last.
    last = (shadow_cap == '0) ? CAP_W'(1) : shadow_cap;
    case (op.action)
      deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_REAR: begin
        if (shadow_count >= last) begin
          // Refuse the push and keep the contents.
          r.full_error = 1'b1;
        end else if (op.action == deq_pkg::ACT_PUSH_FRONT) begin
          slot_mem[shadow_front] = op.value;
          shadow_front = (shadow_front == '0) ? last : shadow_front - 1'b1;
          shadow_count++;
        end else begin
          slot_mem[shadow_rear] = op.value;
          shadow_rear = (shadow_rear >= last) ? '0 : shadow_rear + 1'b1;
          shadow_count++;
        end
      end
      default: begin
        if (shadow_count == '0) begin
          // Popping an empty deque yields zero and flags it.
          r.empty_error = 1'b1;
        end else if (op.action == deq_pkg::ACT_POP_FRONT) begin
          shadow_front = (shadow_front >= last) ? '0 : shadow_front + 1'b1;
          r.value_out  = slot_mem[shadow_front];
          shadow_count--;
        end else begin
          shadow_rear = (shadow_rear == '0) ? last : shadow_rear - 1'b1;
          r.value_out = slot_mem[shadow_rear];
          shadow_count--;
        end
      end
    endcase
    r.count_after = shadow_count;
    return r;
  endfunction

  function automatic deq_op_t mk_op(deq_pkg::deq_action_e a, logic [ELEM_W-1:0] v);
    deq_op_t op;
    op.action = a;
    op.value  = v;
    return op;
  endfunction

  // Queue n random operations; push_pct sets the share of pushes so that a
  // phase can drive the deque toward full or toward empty.
  task automatic queue_random_ops(input int n, input int unsigned push_pct);
    deq_op_t op;
    logic    at_front;
    repeat (n) begin
      at_front = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < push_pct)
        op.action = at_front ? deq_pkg::ACT_PUSH_FRONT : deq_pkg::ACT_PUSH_REAR;
      else
        op.action = at_front ? deq_pkg::ACT_POP_FRONT : deq_pkg::ACT_POP_REAR;
      case ($urandom_range(0, 7))
        0:       op.value = '0;
        1:       op.value = '1;
        default: op.value = $urandom;
      endcase
      pending_ops.push_back(op);
    end
  endtask

  // Hold the sender until every operation has been transferred and every
  // reply has come back, then let the slow pop path settle.
  task automatic drain_all();
    while (pending_ops.size() != 0 || expected_replies.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the capacity register while idle; the write empties the deque.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    @(posedge clk_i);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.capacity <= cap;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    shadow_cap   = cap;
    shadow_front = '0;
    shadow_rear  = CAP_W'(1);
    shadow_count = '0;
  endtask

  // Sender: offer the head of pending_ops in bursts of random length with
  // random gaps. A gap only opens after a transfer, so valid never drops
  // while an operation waits for ready.
  int unsigned burst_left = 10;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin : in_driver
    logic offer;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_replies.push_back(shadow_deque_apply(pending_ops.pop_front()));
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end
      offer = 1'b0;
      if (gap_left != 0)
        gap_left--;
      else if (pending_ops.size() != 0)
        offer = 1'b1;
      in_ch.valid <= offer;
      if (offer) begin
        in_ch.action   <= pending_ops[0].action;
        in_ch.value_in <= pending_ops[0].value;
      end
    end else begin
      in_ch.valid    <= 1'b0;
      in_ch.action   <= deq_pkg::ACT_PUSH_FRONT;
      in_ch.value_in <= '0;
    end
  end

  // Receiver: check each reply transfer against the oldest expectation and
  // stall on a rotating random mask. Once, deep in the run, hold ready low
  // for a long stretch so that the block backs up and stalls its input.
  logic [31:0] stall_mask     = '1;
  logic [4:0]  mask_pos       = '0;
  int unsigned replies_seen   = 0;
  int unsigned long_hold_left = 0;
  logic        long_hold_done = 1'b0;

  always @(posedge clk_i) begin : out_monitor
    deq_reply_t exp_r;
    logic       rdy;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        replies_seen++;
        if (expected_replies.size() == 0) begin
          mismatch_count++;
          $display("%0t: reply expected none, actual value_out %h count_after %0d",
                   $time, out_ch.value_out, out_ch.count_after);
        end else begin
          exp_r = expected_replies.pop_front();
          if (out_ch.value_out !== exp_r.value_out) begin
            mismatch_count++;
            $display("%0t: value_out expected %h actual %h",
                     $time, exp_r.value_out, out_ch.value_out);
          end
          if (out_ch.empty_error !== exp_r.empty_error) begin
            mismatch_count++;
            $display("%0t: empty_error expected %b actual %b",
                     $time, exp_r.empty_error, out_ch.empty_error);
          end
          if (out_ch.full_error !== exp_r.full_error) begin
            mismatch_count++;
            $display("%0t: full_error expected %b actual %b",
                     $time, exp_r.full_error, out_ch.full_error);
          end
          if (out_ch.count_after !== exp_r.count_after) begin
            mismatch_count++;
            $display("%0t: count_after expected %0d actual %0d",
                     $time, exp_r.count_after, out_ch.count_after);
          end
        end
      end

      if (!long_hold_done && replies_seen >= 400) begin
        long_hold_done = 1'b1;
        long_hold_left = 300;
      end

      if (long_hold_left != 0) begin
        long_hold_left--;
        rdy = 1'b0;
      end else begin
        rdy = stall_mask[mask_pos];
        mask_pos++;
        // Pick a new pattern each time mask_pos wraps: none, light, even or heavy stall.
        if (mask_pos == '0) begin
          case ($urandom_range(0, 3))
            0:       stall_mask = '1;
            1:       stall_mask = $urandom | $urandom;
            2:       stall_mask = $urandom;
            default: stall_mask = $urandom & $urandom;
          endcase
        end
      end
      out_ch.ready <= rdy;
    end else begin
      out_ch.ready <= 1'b0;
    end
  end

  initial begin
    // Drive the reset and the configuration inputs from time zero.
    rst_ni          = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.capacity = '0;
    foreach (slot_mem[i]) slot_mem[i] = '0;
    shadow_cap   = deq_pkg::CAP_RESET;
    shadow_front = '0;
    shadow_rear  = CAP_W'(1);
    shadow_count = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset capacity: pops on empty from both ends, extreme values, pushes at
    // both ends (front push wraps from slot 0 to the top), pops from both ends.
    pending_ops.push_back(mk_op(deq_pkg::ACT_POP_FRONT, '1));
    pending_ops.push_back(mk_op(deq_pkg::ACT_POP_REAR, '1));
    pending_ops.push_back(mk_op(deq_pkg::ACT_PUSH_FRONT, '1));
    pending_ops.push_back(mk_op(deq_pkg::ACT_PUSH_REAR, '0));
    pending_ops.push_back(mk_op(deq_pkg::ACT_PUSH_FRONT, 32'h1234_5678));
    pending_ops.push_back(mk_op(deq_pkg::ACT_PUSH_REAR, 32'hA5A5_A5A5));
    pending_ops.push_back(mk_op(deq_pkg::ACT_POP_REAR, '0));
    pending_ops.push_back(mk_op(deq_pkg::ACT_POP_FRONT, '0));
    pending_ops.push_back(mk_op(deq_pkg::ACT_POP_REAR, '1));
    pending_ops.push_back(mk_op(deq_pkg::ACT_POP_FRONT, '1));
    pending_ops.push_back(mk_op(deq_pkg::ACT_POP_FRONT, '0));
    queue_random_ops(30, 50);
    drain_all();

    // Capacity one: push when full from either end, pop on empty.
    write_capacity(CAP_W'(1));
    pending_ops.push_back(mk_op(deq_pkg::ACT_PUSH_REAR, '1));
    pending_ops.push_back(mk_op(deq_pkg::ACT_PUSH_FRONT, 32'h0000_0001));
    pending_ops.push_back(mk_op(deq_pkg::ACT_PUSH_REAR, 32'h0000_0002));
    pending_ops.push_back(mk_op(deq_pkg::ACT_POP_FRONT, '0));
    pending_ops.push_back(mk_op(deq_pkg::ACT_POP_REAR, '0));
    pending_ops.push_back(mk_op(deq_pkg::ACT_PUSH_FRONT, '0));
    pending_ops.push_back(mk_op(deq_pkg::ACT_POP_REAR, '0));
    queue_random_ops(25, 50);
    drain_all();

    // Capacity zero acts as capacity one.
    write_capacity('0);
    pending_ops.push_back(mk_op(deq_pkg::ACT_PUSH_FRONT, 32'h0000_0005));
    pending_ops.push_back(mk_op(deq_pkg::ACT_PUSH_REAR, 32'h0000_0006));
    pending_ops.push_back(mk_op(deq_pkg::ACT_POP_REAR, '0));
    queue_random_ops(20, 50);
    drain_all();

    // Small rings wrap often and hit full and empty repeatedly.
    write_capacity(CAP_W'(2));
    queue_random_ops(30, 55);
    drain_all();
    write_capacity(CAP_W'(3));
    queue_random_ops(30, 55);
    drain_all();
    write_capacity(CAP_W'($urandom_range(4, 40)));
    queue_random_ops(50, 55);
    drain_all();

    // Full capacity written explicitly: fill to the top, refuse pushes there,
    // then drain part of it.
    write_capacity(CAP_W'(255));
    queue_random_ops(330, 95);
    queue_random_ops(70, 10);
    drain_all();

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule

/* filelist.f */
src/deq_pkg.sv
src/deq_if.sv
src/deq_cell.sv
src/deq_tail_tree.sv
src/double_ended_queue_core.sv
test/tb.sv
